// ===== hw/rtl/segment_search_with_lerp_macros.svh =====
// Assertion macros used by the checker file of the segment search block.
// No dependencies; included by the checker with a plain include.
`ifndef SEGMENT_SEARCH_WITH_LERP_MACROS_SVH
`define SEGMENT_SEARCH_WITH_LERP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSWL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSWL_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sswl_pkg.sv =====
// Package of the segment search block: shared constants, operation codes and types.
// No dependencies; used by the subtractor, the top level and the checker.
package sswl_pkg;

  localparam int unsigned DepthDef    = 1024;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned TimeW       = 32;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic             borrow;
    logic [TimeW:0]   diff;
  } sub_res_t;

endpackage

// ===== hw/rtl/sswl_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds the timestamp table of the segment search block.
module sswl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sswl_sub.sv =====
// Shared subtract and compare unit of the segment search block.
// Depends on sswl_pkg for the operand width and the result struct.
module sswl_sub (
  input  logic [sswl_pkg::TimeW:0] a_i,
  input  logic [sswl_pkg::TimeW:0] b_i,
  output sswl_pkg::sub_res_t       res_o
);
  import sswl_pkg::*;

  logic [TimeW+1:0] full;

  assign full         = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.borrow = full[TimeW+1];
  assign res_o.diff   = full[TimeW:0];

endmodule

// ===== hw/rtl/segment_search_with_lerp.sv =====
// Segment search with linear interpolation over a table of ascending timestamps.
// A load transaction writes one table entry and leaves the block ready for the next item.
// A query runs a binary search of ceil(log2(n)) probes for n vertices, each a probe and
// a compare state around the registered table read, then fetches the segment ends and runs
// a serial division of FRAC_BITS quotient bits. Reset is asynchronous and active low; it clears
// the sequencer, vertex_count and the output valid, but not the table contents.
module segment_search_with_lerp #(
  parameter int unsigned DEPTH     = sswl_pkg::DepthDef,
  parameter int unsigned FRAC_BITS = sswl_pkg::FracBitsDef,
  localparam int unsigned IdxW   = $clog2(DEPTH),
  localparam int unsigned CntW   = $clog2(DEPTH + 1),
  localparam int unsigned LerpW  = FRAC_BITS + 1,
  localparam int unsigned SDataW = ((IdxW + 2 * sswl_pkg::TimeW + 7) / 8) * 8,
  localparam int unsigned MDataW = ((IdxW + LerpW + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CntW-1:0]   cfg_data_i,     // vertex_count
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [SDataW-1:0] s_axis_tdata,   // entry_index, entry_time, query_time, zero pad
  input  logic              s_axis_tuser,   // operation
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [MDataW-1:0] m_axis_tdata,   // segment_index, lerp_factor, zero pad
  output logic              m_axis_tuser    // segment_found
);
  import sswl_pkg::*;

  localparam int unsigned CycW = $clog2(FRAC_BITS + 1);
  localparam logic [LerpW-1:0] One = LerpW'(1) << FRAC_BITS;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StProbe = 3'd1;
  localparam logic [2:0] StCmp   = 3'd2;
  localparam logic [2:0] StT0    = 3'd3;
  localparam logic [2:0] StT1    = 3'd4;
  localparam logic [2:0] StChk   = 3'd5;
  localparam logic [2:0] StDiv   = 3'd6;
  localparam logic [2:0] StDone  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  vcount_q;
  logic [CntW-1:0]  n_used;
  logic [IdxW-1:0]  lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, mid;
  logic [IdxW:0]    mid_sum;
  logic [TimeW-1:0] q_q, q_d, t0_q, t0_d, num_q, num_d, dur_q, dur_d, rem_q, rem_d;
  logic [LerpW-1:0] frac_q, frac_d;
  logic [CycW-1:0]  cnt_q, cnt_d;
  logic             m_valid_q, m_load;
  logic [IdxW-1:0]  m_idx_q;
  logic [LerpW-1:0] m_frac_q;

  logic             s_fire;
  logic [IdxW-1:0]  in_idx;
  logic [TimeW-1:0] in_etime, in_qtime;
  logic             ram_we;
  logic [IdxW-1:0]  ram_raddr;
  logic [TimeW-1:0] ram_rdata;
  logic [TimeW:0]   sub_a, sub_b;
  sub_res_t         sub_res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign in_idx   = s_axis_tdata[IdxW-1:0];
  assign in_etime = s_axis_tdata[IdxW+TimeW-1:IdxW];
  assign in_qtime = s_axis_tdata[IdxW+2*TimeW-1:IdxW+TimeW];

  assign n_used  = (vcount_q > CntW'(DEPTH)) ? CntW'(DEPTH) : vcount_q;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IdxW:1];

  assign ram_we = s_fire && (s_axis_tuser == OpLoad) &&
                  ({1'b0, in_idx} < (IdxW + 1)'(DEPTH));

  sswl_ram #(
    .WIDTH (TimeW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_idx),
    .wdata_i (in_etime),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sswl_sub u_sub (
    .a_i   (sub_a),
    .b_i   (sub_b),
    .res_o (sub_res)
  );

  always_comb begin
    unique case (state_q)
      StCmp: begin
        sub_a = {1'b0, ram_rdata};
        sub_b = {1'b0, q_q};
      end
      StT0: begin
        sub_a = {1'b0, q_q};
        sub_b = {1'b0, ram_rdata};
      end
      StT1: begin
        sub_a = {1'b0, ram_rdata};
        sub_b = {1'b0, t0_q};
      end
      StChk: begin
        sub_a = {1'b0, num_q};
        sub_b = {1'b0, dur_q};
      end
      StDiv: begin
        sub_a = {rem_q, 1'b0};
        sub_b = {1'b0, dur_q};
      end
      default: begin
        sub_a = {1'b0, ram_rdata};
        sub_b = {1'b0, q_q};
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    q_d       = q_q;
    t0_d      = t0_q;
    num_d     = num_q;
    dur_d     = dur_q;
    rem_d     = rem_q;
    frac_d    = frac_q;
    cnt_d     = cnt_q;
    ram_raddr = mid;
    m_load    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (s_fire && (s_axis_tuser == OpQuery) && (n_used >= CntW'(2))) begin
          lo_d    = '0;
          hi_d    = IdxW'(n_used - CntW'(1));
          q_d     = in_qtime;
          state_d = StProbe;
        end
      end
      StProbe: begin
        if (lo_q < hi_q) begin
          mid_d   = mid;
          state_d = StCmp;
        end else if (hi_q == '0) begin
          state_d = StIdle;
        end else begin
          ram_raddr = IdxW'(hi_q - 1'b1);
          state_d   = StT0;
        end
      end
      StCmp: begin
        if (sub_res.borrow) begin
          lo_d = IdxW'(mid_q + 1'b1);
        end else begin
          hi_d = mid_q;
        end
        state_d = StProbe;
      end
      StT0: begin
        t0_d      = ram_rdata;
        num_d     = sub_res.diff[TimeW-1:0];
        ram_raddr = hi_q;
        state_d   = StT1;
      end
      StT1: begin
        if (sub_res.borrow || (sub_res.diff == '0)) begin
          frac_d  = '0;
          state_d = StDone;
        end else begin
          dur_d   = sub_res.diff[TimeW-1:0];
          state_d = StChk;
        end
      end
      StChk: begin
        if (!sub_res.borrow) begin
          frac_d  = One;
          state_d = StDone;
        end else begin
          rem_d   = num_q;
          frac_d  = '0;
          cnt_d   = CycW'(FRAC_BITS);
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (sub_res.borrow) begin
          rem_d = {rem_q[TimeW-2:0], 1'b0};
        end else begin
          rem_d = sub_res.diff[TimeW-1:0];
        end
        frac_d = {frac_q[LerpW-2:0], ~sub_res.borrow};
        cnt_d  = CycW'(cnt_q - 1'b1);
        if (cnt_q == CycW'(1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!m_valid_q || m_axis_tready) begin
          m_load  = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      vcount_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_data_i;
      end
      if (m_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    q_q    <= q_d;
    t0_q   <= t0_d;
    num_q  <= num_d;
    dur_q  <= dur_d;
    rem_q  <= rem_d;
    frac_q <= frac_d;
    cnt_q  <= cnt_d;
    if (m_load) begin
      m_idx_q  <= IdxW'(hi_q - 1'b1);
      m_frac_q <= frac_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = 1'b1;
  assign m_axis_tdata  = MDataW'({m_frac_q, m_idx_q});

endmodule

// ===== hw/rtl/sswl_checker.sv =====
// Port-level checker of the segment search block, bound to its top level.
// Depends on sswl_pkg and on the assertion macros header.
`include "segment_search_with_lerp_macros.svh"

module sswl_checker #(
  parameter int unsigned DEPTH     = sswl_pkg::DepthDef,
  parameter int unsigned FRAC_BITS = sswl_pkg::FracBitsDef,
  localparam int unsigned IdxW   = $clog2(DEPTH),
  localparam int unsigned LerpW  = FRAC_BITS + 1,
  localparam int unsigned MDataW = ((IdxW + LerpW + 7) / 8) * 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              s_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [MDataW-1:0] m_axis_tdata
);
  import sswl_pkg::*;

  localparam logic [LerpW-1:0] One    = LerpW'(1) << FRAC_BITS;
  localparam logic [IdxW-1:0]  MaxSeg = IdxW'(DEPTH - 2);

  logic [IdxW-1:0]  seg_idx;
  logic [LerpW-1:0] lerp;

  assign seg_idx = m_axis_tdata[IdxW-1:0];
  assign lerp    = m_axis_tdata[IdxW+LerpW-1:IdxW];

  // A stalled result must hold until it is taken.
  `SSWL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // A load transaction never produces a result.
  `SSWL_ASSERT_NXT(a_load_silent, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OpLoad) && !m_axis_tvalid, !m_axis_tvalid, "load produced a result")

  // The interpolation fraction saturates at one.
  `SSWL_ASSERT_IMP(a_lerp_range, clk_i, rst_ni, m_axis_tvalid, lerp <= One, "lerp factor above one")

  // A segment always starts below the last table entry.
  `SSWL_ASSERT_IMP(a_seg_range, clk_i, rst_ni, m_axis_tvalid, seg_idx <= MaxSeg, "segment index out of range")

endmodule

bind segment_search_with_lerp sswl_checker #(
  .DEPTH     (DEPTH),
  .FRAC_BITS (FRAC_BITS)
) u_sswl_checker (.*);

// ===== dv/segment_search_with_lerp_tb.sv =====
// Self-checking testbench of segment_search_with_lerp: table loads and time queries are
// checked against an in-bench segment search and lerp predictor.
// Depends on sswl_pkg and the segment_search_with_lerp RTL only.
module segment_search_with_lerp_tb;
  import sswl_pkg::*;

  localparam int unsigned Depth        = 1024;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned IdxW         = 10;
  localparam int unsigned CntW         = 11;
  localparam int unsigned LerpW        = FracBits + 1;
  localparam int unsigned SDataW       = 80;
  localparam int unsigned MDataW       = 32;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned ItemTarget   = 1700;

  typedef struct {
    logic            op;
    logic [IdxW-1:0] idx;
    logic [31:0]     etime;
    logic [31:0]     qtime;
  } table_item_t;

  typedef struct packed {
    logic             found;
    logic [IdxW-1:0]  seg;
    logic [LerpW-1:0] lerp;
  } segment_hit_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [CntW-1:0]   cfg_data_i    = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [SDataW-1:0] s_axis_tdata  = '0;  // entry_index, entry_time, query_time, zero pad
  logic              s_axis_tuser  = 1'b0; // operation
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [MDataW-1:0] m_axis_tdata;        // segment_index, lerp_factor, zero pad
  logic              m_axis_tuser;        // segment_found

  table_item_t  pending_items[$];
  table_item_t  item_on_bus;
  segment_hit_t hit_expect_q[$];
  segment_hit_t predicted_hit;
  segment_hit_t expected_hit;

  bit [31:0]   time_shadow[Depth];
  int unsigned vertex_count_shadow = 0;
  bit [31:0]   plan_time[Depth];
  bit          plan_written[Depth];

  bit          burst_mode  = 1'b0;
  bit          long_hold   = 1'b0;
  int unsigned send_gap    = 0;
  int unsigned ready_stall = 0;
  int unsigned n_errors    = 0;
  int unsigned n_queued    = 0;

  segment_search_with_lerp uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 16);
    return $urandom_range(40, 150);
  endfunction

  // Lower-bound search over the active entries; the segment starts one entry before the hit.
  function automatic bit locate_segment(input bit [31:0] q, output segment_hit_t hit);
    int unsigned n, lo, hi, mid;
    bit [31:0] t0, t1, offset, span;
    bit [47:0] scaled;
    hit = '0;
    n = (vertex_count_shadow > Depth) ? Depth : vertex_count_shadow;
    if (n < 2) return 1'b0;
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (time_shadow[mid] < q) lo = mid + 1;
      else hi = mid;
    end
    if (hi == 0) return 1'b0;
    t0 = time_shadow[hi-1];
    t1 = time_shadow[hi];
    hit.found = 1'b1;
    hit.seg = IdxW'(hi - 1);
    if (t1 > t0) begin
      offset = q - t0;
      span = t1 - t0;
      if (offset >= span) begin
        hit.lerp = LerpW'(1 << FracBits);
      end else begin
        scaled = (48'(offset) << FracBits) / 48'(span);
        hit.lerp = scaled[LerpW-1:0];
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (item_on_bus.op == OpLoad) time_shadow[item_on_bus.idx] = item_on_bus.etime;
        else if (locate_segment(item_on_bus.qtime, predicted_hit))
          hit_expect_q.push_back(predicted_hit);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          item_on_bus = pending_items.pop_front();
          s_axis_tuser <= item_on_bus.op;
          s_axis_tdata <= {6'd0, item_on_bus.qtime, item_on_bus.etime, item_on_bus.idx};
          s_axis_tvalid <= 1'b1;
          send_gap = burst_mode ? 0 : draw_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (hit_expect_q.size() == 0) begin
          $error("unexpected result transaction: segment_index %0d, lerp_factor 0x%0h",
                 m_axis_tdata[IdxW-1:0], m_axis_tdata[IdxW +: LerpW]);
          n_errors++;
        end else begin
          expected_hit = hit_expect_q.pop_front();
          if (m_axis_tuser !== expected_hit.found) begin
            $error("segment_found: expected %0d, actual %0d", expected_hit.found, m_axis_tuser);
            n_errors++;
          end
          if (m_axis_tdata[IdxW-1:0] !== expected_hit.seg) begin
            $error("segment_index: expected %0d, actual %0d", expected_hit.seg,
                   m_axis_tdata[IdxW-1:0]);
            n_errors++;
          end
          if (m_axis_tdata[IdxW +: LerpW] !== expected_hit.lerp) begin
            $error("lerp_factor: expected 0x%0h, actual 0x%0h", expected_hit.lerp,
                   m_axis_tdata[IdxW +: LerpW]);
            n_errors++;
          end
        end
      end
      if (long_hold) begin
        m_axis_tready <= 1'b0;
      end else if (ready_stall > 0) begin
        ready_stall--;
        m_axis_tready <= 1'b0;
      end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
        ready_stall = draw_gap();
        m_axis_tready <= (ready_stall == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_load(input int unsigned idx, input bit [31:0] t);
    table_item_t it;
    it.op = OpLoad;
    it.idx = IdxW'(idx);
    it.etime = t;
    it.qtime = $urandom;
    plan_time[idx] = t;
    plan_written[idx] = 1'b1;
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic push_query(input bit [31:0] q);
    table_item_t it;
    it.op = OpQuery;
    it.idx = IdxW'($urandom);
    it.etime = $urandom;
    it.qtime = q;
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || hit_expect_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_count(input int unsigned n);
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= CntW'(n);
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    vertex_count_shadow = n;
  endtask

  initial begin
    int unsigned phase, n, n_eff, n_queries, k, r, lo_t, hi_t;
    bit [32:0] next_time;
    bit [31:0] t;
    bit needs_fill;
    phase = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Queries against an empty and a single-vertex table produce nothing.
    push_query(32'h0);
    push_query(32'hFFFF_FFFF);
    set_count(1);
    @(negedge clk_i);
    push_query(32'h5);
    push_load(0, 32'h0);
    push_load(1, 32'h100);
    push_load(2, 32'h200);
    push_load(3, 32'h200);
    push_load(1023, 32'hFFFF_FFFF);
    set_count(4);
    @(negedge clk_i);
    push_query(32'h0);
    push_query(32'h80);
    push_query(32'h100);
    push_query(32'h101);
    push_query(32'h200);
    push_query(32'h300);
    push_query(32'hFFFF_FFFF);
    // Break the ordering to exercise the search on an unsorted table.
    push_load(1, 32'h300);
    push_query(32'h250);
    push_query(32'h2FF);
    set_count(2);
    @(negedge clk_i);
    push_query(32'h180);
    push_query(32'h300);
    push_query(32'h400);

    while (n_queued < ItemTarget) begin
      case (phase)
        0: n = 1024;
        1: n = 2047;
        2: n = 0;
        3: n = 1;
        4: n = 1025;
        5: n = 200;
        default: begin
          r = $urandom_range(0, 19);
          if (r < 12) n = $urandom_range(2, 40);
          else if (r < 16) n = $urandom_range(41, 300);
          else if (r < 18) n = $urandom_range(0, 1);
          else if (r < 19) n = $urandom_range(1000, 1024);
          else n = $urandom_range(1025, 2047);
        end
      endcase
      set_count(n);
      @(negedge clk_i);
      burst_mode = ($urandom_range(0, 3) == 0);
      n_eff = (n > Depth) ? Depth : n;

      needs_fill = (n_eff <= 64);
      for (int unsigned i = 0; i < n_eff; i++)
        if (!plan_written[i]) needs_fill = 1'b1;
      if (needs_fill) begin
        t = $urandom_range(0, 1) ? $urandom_range(0, 32'hFFFF) : $urandom_range(0, 32'h7FFF_FFFF);
        for (int unsigned i = 0; i < n_eff; i++) begin
          push_load(i, t);
          r = $urandom_range(0, 9);
          if (r == 0) next_time = t;
          else if (r < 4) next_time = t + $urandom_range(1, 255);
          else if (r < 8) next_time = t + $urandom_range(256, 32'h2_0000);
          else next_time = t + $urandom_range(1, 32'h100_0000);
          t = next_time[32] ? 32'hFFFF_FFFF : next_time[31:0];
        end
        if (n_eff >= 3 && $urandom_range(0, 3) == 0)
          push_load($urandom_range(0, n_eff - 1), $urandom);
      end else begin
        repeat (4) begin
          k = $urandom_range(1, n_eff - 2);
          lo_t = plan_time[k-1];
          hi_t = plan_time[k+1];
          if (hi_t >= lo_t) push_load(k, $urandom_range(lo_t, hi_t));
          else push_load(k, $urandom);
        end
      end

      if (phase == 5) long_hold = 1'b1;
      n_queries = (n_eff < 2) ? 4 : $urandom_range(10, 40);
      repeat (n_queries) begin
        if ($urandom_range(0, 9) == 0) begin
          k = $urandom_range(0, Depth - 1);
          push_load(k, plan_written[k] ? plan_time[k] : $urandom);
        end else begin
          r = $urandom_range(0, 19);
          if (n_eff == 0 || r == 2 || r == 3) begin
            t = $urandom;
          end else if (r == 0) begin
            t = 32'h0;
          end else if (r == 1) begin
            t = 32'hFFFF_FFFF;
          end else begin
            k = $urandom_range(0, n_eff - 1);
            t = plan_time[k];
            case (r % 4)
              0: t = t;
              1: t = t - 1;
              2: t = t + 1;
              default: begin
                if (k + 1 < n_eff && plan_time[k+1] > t)
                  t = t + $urandom_range(0, plan_time[k+1] - t);
                else t = t + $urandom_range(0, 255);
              end
            endcase
          end
          push_query(t);
        end
      end
      if (long_hold) begin
        repeat (800) @(negedge clk_i);
        long_hold = 1'b0;
      end
      phase++;
    end

    wait_idle();
    if (n_errors == 0) begin
      $display("segment_search_with_lerp regression: pass");
    end else begin
      $display("segment_search_with_lerp regression: fail");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("segment_search_with_lerp regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sswl_pkg.sv
hw/rtl/sswl_ram.sv
hw/rtl/sswl_sub.sv
hw/rtl/segment_search_with_lerp.sv
hw/rtl/sswl_checker.sv
dv/segment_search_with_lerp_tb.sv
